// ===== src/sound_chip_command_stream_parser_unit_macros.svh =====
// Assertion helpers used by the parser unit RTL.
`ifndef SOUND_CHIP_COMMAND_STREAM_PARSER_UNIT_MACROS_SVH
`define SOUND_CHIP_COMMAND_STREAM_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define SCCSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// checked on every edge, reset included
`define SCCSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCCSP_ASSERT(lbl, clk, rstn, prop, msg)
`define SCCSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/sccsp_pkg.sv =====
package sccsp_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_LOOP  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_OPCODE   = 2'd0,
    PH_REGISTER = 2'd1,
    PH_DATA     = 2'd2,
    PH_DELAY    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_LOOP_EN   = 2'd0,
    CFG_DEV_COUNT = 2'd1,
    CFG_PSG_MASK  = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] OpWaitOne = 8'hFF;
  localparam logic [7:0] OpDelay   = 8'hFE;
  localparam logic [7:0] OpLoop    = 8'hFD;

  localparam logic [2:0] DelayMaxBytes = 3'd5;
  localparam int unsigned DevIdxW = 7;

  typedef struct packed {
    kind_e        kind;
    logic [2:0]   device;
    logic [1:0]   offset;
    logic [7:0]   value;
    logic [31:0]  wait_ticks;
    logic [15:0]  loop_number;
    logic         last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } parse_out_t;

endpackage

// ===== src/sound_chip_command_stream_parser_unit.sv =====
// Results are registered in a result queue and offered on the output from its head.
// Throughput: one stream byte per cycle while the output side keeps up; a register
// write to a two-port device queues two results, and input stalls once the result
// queue holds more than two entries.
// Reset (rst_ni low, asynchronous): parser back to opcode phase, counters cleared,
// queue emptied, loop disabled, device count 1, PSG mask 0.
`include "sound_chip_command_stream_parser_unit_macros.svh"

module sound_chip_command_stream_parser_unit #(
  parameter int unsigned MAX_DEVICES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  device_o,
  output logic [1:0]  offset_o,
  output logic [7:0]  value_o,
  output logic [31:0] wait_ticks_o,
  output logic [15:0] loop_number_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sccsp_pkg::parse_out_t par;
  sccsp_pkg::result_t    fifo_q [Depth];
  sccsp_pkg::result_t    head;
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]       wr_ptr_nx;
  logic [CntW-1:0]       count_q, count_d;
  logic                  in_accept;
  logic                  pop;

  // room for the largest burst one request can cause
  assign in_ready_o = count_q <= CntW'(Depth - 2);
  assign in_accept  = in_valid_i && in_ready_o;

  sccsp_parser #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .stream_byte_i(stream_byte_i),
    .stream_end_i (stream_end_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .par_o        (par)
  );

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;

  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);
  assign wr_ptr_d  = wr_ptr_q + PtrW'(par.count);
  assign rd_ptr_d  = rd_ptr_q + PtrW'(pop);
  assign count_d   = count_q + CntW'(par.count) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (par.count != 2'd0) begin
      fifo_q[wr_ptr_q] <= par.first;
    end
    if (par.count == 2'd2) begin
      fifo_q[wr_ptr_nx] <= par.second;
    end
  end

  assign kind_o        = head.kind;
  assign device_o      = head.device;
  assign offset_o      = head.offset;
  assign value_o       = head.value;
  assign wait_ticks_o  = head.wait_ticks;
  assign loop_number_o = head.loop_number;
  assign last_o        = head.last;

  `SCCSP_ASSERT(a_burst_last, clk_i, rst_ni,
                (par.count == 2'd2) |-> (!par.first.last && par.second.last),
                "two-result burst must mark only its second result last")
  `SCCSP_ASSERT(a_burst_follows, clk_i, rst_ni, (pop && !last_o) |=> out_valid_o,
                "second result of a burst missing")
  `SCCSP_ASSERT(a_nonwrite_clean, clk_i, rst_ni,
                (out_valid_o && kind_o != sccsp_pkg::KIND_WRITE) |->
                (device_o == 3'd0 && offset_o == 2'd0 && value_o == 8'd0),
                "non-write result carries write fields")
  `SCCSP_ASSERT(a_end_final, clk_i, rst_ni,
                (pop && kind_o == sccsp_pkg::KIND_END) |=> !out_valid_o,
                "result queued after end of stream")
  `SCCSP_ASSERT_ALWAYS(a_count_bound, clk_i, (!rst_ni || count_q <= CntW'(Depth)),
                       "result queue overflow")

endmodule

// ===== src/sccsp_parser.sv =====
module sccsp_parser #(
  parameter int unsigned MAX_DEVICES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            stream_byte_i,
  input  logic                  stream_end_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  output sccsp_pkg::parse_out_t par_o
);

  localparam logic [sccsp_pkg::DevIdxW-1:0] MaxDev = sccsp_pkg::DevIdxW'(MAX_DEVICES);

  logic       loop_en_q;
  logic [3:0] dev_count_q;
  logic [7:0] psg_mask_q;

  sccsp_pkg::phase_e                 phase_q, phase_d;
  logic [sccsp_pkg::DevIdxW-1:0]     dev_q, dev_d;
  logic                              port_q, port_d;
  logic [7:0]                        reg_q, reg_d;
  logic [31:0]                       acc_q, acc_d;
  logic [2:0]                        cnt_q, cnt_d;
  logic [15:0]                       loop_q, loop_d;
  logic                              ended_q, ended_d;

  logic [35:0]                       part;
  logic [35:0]                       acc_sum;
  logic [35:0]                       term_sum;
  logic [31:0]                       acc_sat;
  logic [31:0]                       term_sat;
  logic [sccsp_pkg::DevIdxW-1:0]     limit;
  logic                              dev_ok;
  logic                              is_psg;
  sccsp_pkg::result_t                blank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en_q   <= 1'b0;
      dev_count_q <= 4'd1;
      psg_mask_q  <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sccsp_pkg::CFG_LOOP_EN:   loop_en_q   <= cfg_data_i[0];
        sccsp_pkg::CFG_DEV_COUNT: dev_count_q <= cfg_data_i[3:0];
        sccsp_pkg::CFG_PSG_MASK:  psg_mask_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sccsp_pkg::PH_OPCODE;
      dev_q   <= '0;
      port_q  <= 1'b0;
      reg_q   <= 8'd0;
      acc_q   <= 32'd0;
      cnt_q   <= 3'd0;
      loop_q  <= 16'd0;
      ended_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      dev_q   <= dev_d;
      port_q  <= port_d;
      reg_q   <= reg_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      loop_q  <= loop_d;
      ended_q <= ended_d;
    end
  end

  // 7-bit group placed at its little-endian position; groups past the fifth add nothing
  always_comb begin
    unique case (cnt_q)
      3'd0:    part = {29'd0, stream_byte_i[6:0]};
      3'd1:    part = {22'd0, stream_byte_i[6:0], 7'd0};
      3'd2:    part = {15'd0, stream_byte_i[6:0], 14'd0};
      3'd3:    part = {8'd0, stream_byte_i[6:0], 21'd0};
      3'd4:    part = {1'b0, stream_byte_i[6:0], 28'd0};
      default: part = 36'd0;
    endcase
  end

  assign acc_sum  = {4'd0, acc_q} + part;
  assign term_sum = {4'd0, acc_q} + part + 36'd2;
  assign acc_sat  = (|acc_sum[35:32]) ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign term_sat = (|term_sum[35:32]) ? 32'hFFFF_FFFF : term_sum[31:0];

  assign limit  = ({3'd0, dev_count_q} > MaxDev) ? MaxDev : {3'd0, dev_count_q};
  assign dev_ok = dev_q < limit;
  assign is_psg = (dev_q < sccsp_pkg::DevIdxW'(8)) && psg_mask_q[dev_q[2:0]];

  always_comb begin
    blank = '{kind: sccsp_pkg::KIND_WRITE, device: 3'd0, offset: 2'd0, value: 8'd0,
              wait_ticks: 32'd0, loop_number: 16'd0, last: 1'b1};
    phase_d = phase_q;
    dev_d   = dev_q;
    port_d  = port_q;
    reg_d   = reg_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    loop_d  = loop_q;
    ended_d = ended_q;
    par_o.count  = 2'd0;
    par_o.first  = blank;
    par_o.second = blank;

    if (accept_i && !ended_q) begin
      if (stream_end_i) begin
        ended_d = 1'b1;
        phase_d = sccsp_pkg::PH_OPCODE;
        par_o.count      = 2'd1;
        par_o.first.kind = sccsp_pkg::KIND_END;
      end else begin
        unique case (phase_q)
          sccsp_pkg::PH_OPCODE: begin
            priority if (stream_byte_i == sccsp_pkg::OpWaitOne) begin
              par_o.count            = 2'd1;
              par_o.first.kind       = sccsp_pkg::KIND_WAIT;
              par_o.first.wait_ticks = 32'd1;
            end else if (stream_byte_i == sccsp_pkg::OpDelay) begin
              acc_d   = 32'd0;
              cnt_d   = 3'd0;
              phase_d = sccsp_pkg::PH_DELAY;
            end else if (stream_byte_i == sccsp_pkg::OpLoop) begin
              par_o.count = 2'd1;
              if (!loop_en_q) begin
                ended_d          = 1'b1;
                par_o.first.kind = sccsp_pkg::KIND_END;
              end else begin
                loop_d = (loop_q == 16'hFFFF) ? loop_q : loop_q + 16'd1;
                par_o.first.kind        = sccsp_pkg::KIND_LOOP;
                par_o.first.loop_number = loop_d;
              end
            end else begin
              dev_d   = stream_byte_i[7:1];
              port_d  = stream_byte_i[0];
              phase_d = sccsp_pkg::PH_REGISTER;
            end
          end
          sccsp_pkg::PH_REGISTER: begin
            reg_d   = stream_byte_i;
            phase_d = sccsp_pkg::PH_DATA;
          end
          sccsp_pkg::PH_DATA: begin
            phase_d = sccsp_pkg::PH_OPCODE;
            if (dev_ok) begin
              par_o.first.device = dev_q[2:0];
              if (is_psg) begin
                par_o.count        = 2'd1;
                par_o.first.offset = (reg_q == 8'd1) ? 2'd1 : 2'd0;
                par_o.first.value  = stream_byte_i;
              end else begin
                // address write, then data write
                par_o.count         = 2'd2;
                par_o.first.offset  = {port_q, 1'b0};
                par_o.first.value   = reg_q;
                par_o.first.last    = 1'b0;
                par_o.second.device = dev_q[2:0];
                par_o.second.offset = {port_q, 1'b1};
                par_o.second.value  = stream_byte_i;
              end
            end
          end
          sccsp_pkg::PH_DELAY: begin
            acc_d = acc_sat;
            if (cnt_q < sccsp_pkg::DelayMaxBytes) begin
              cnt_d = cnt_q + 3'd1;
            end
            if (!stream_byte_i[7]) begin
              phase_d = sccsp_pkg::PH_OPCODE;
              acc_d   = 32'd0;
              cnt_d   = 3'd0;
              par_o.count            = 2'd1;
              par_o.first.kind       = sccsp_pkg::KIND_WAIT;
              par_o.first.wait_ticks = term_sat;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxDevices = 8;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       at_end;
  } stream_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = 8'h00;
  logic        stream_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [2:0]  device_o;
  logic [1:0]  offset_o;
  logic [7:0]  value_o;
  logic [31:0] wait_ticks_o;
  logic [15:0] loop_number_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [7:0]  cfg_data_i = 8'h00;

  sound_chip_command_stream_parser_unit #(
    .MAX_DEVICES(MaxDevices)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stream_byte_i(stream_byte_i),
    .stream_end_i (stream_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .device_o     (device_o),
    .offset_o     (offset_o),
    .value_o      (value_o),
    .wait_ticks_o (wait_ticks_o),
    .loop_number_o(loop_number_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the configuration registers
  logic        cfg_loop_en = 1'b0;
  logic [3:0]  cfg_dev_count = 4'd1;
  logic [7:0]  cfg_psg_mask = 8'h00;

  // Parser state mirror
  sccsp_pkg::phase_e phase = sccsp_pkg::PH_OPCODE;
  logic [6:0]  hold_dev = '0;
  logic        hold_port = 1'b0;
  logic [7:0]  hold_reg = '0;
  logic [31:0] delay_sum = '0;
  logic [2:0]  delay_bytes = '0;
  logic [15:0] loop_cnt = '0;
  logic        stream_done = 1'b0;

  stream_req_t        pending_bytes[$];
  sccsp_pkg::result_t due_events[$];
  stream_req_t        next_req;
  sccsp_pkg::result_t want_ev;

  int unsigned send_idle = 37;
  int unsigned recv_idle = 54;
  int unsigned queued_bytes = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  int unsigned count_plan [9] = '{15, 0, 3, 8, 1, 9, 5, 8, 2};
  bit          loop_plan [9] = '{1, 0, 1, 1, 0, 1, 0, 1, 1};
  logic [7:0]  mask_plan [9] = '{8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h00, 8'hC3, 8'h81, 8'h3C,
                                 8'hFF};

  function automatic logic [31:0] sat32(input logic [39:0] s);
    return (s > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void add_event(input sccsp_pkg::kind_e k, input logic [2:0] dev,
                                    input logic [1:0] ofs, input logic [7:0] val,
                                    input logic [31:0] ticks, input logic [15:0] lp,
                                    input logic lst);
    sccsp_pkg::result_t r;
    r.kind        = k;
    r.device      = dev;
    r.offset      = ofs;
    r.value       = val;
    r.wait_ticks  = ticks;
    r.loop_number = lp;
    r.last        = lst;
    due_events.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eos);
    logic [3:0] limit;
    logic       psg;
    if (stream_done) return;
    if (eos) begin
      stream_done = 1'b1;
      phase = sccsp_pkg::PH_OPCODE;
      add_event(sccsp_pkg::KIND_END, 3'd0, 2'd0, 8'd0, 32'd0, 16'd0, 1'b1);
      return;
    end
    case (phase)
      sccsp_pkg::PH_OPCODE: begin
        if (b == sccsp_pkg::OpWaitOne) begin
          add_event(sccsp_pkg::KIND_WAIT, 3'd0, 2'd0, 8'd0, 32'd1, 16'd0, 1'b1);
        end else if (b == sccsp_pkg::OpDelay) begin
          delay_sum = '0;
          delay_bytes = '0;
          phase = sccsp_pkg::PH_DELAY;
        end else if (b == sccsp_pkg::OpLoop) begin
          if (!cfg_loop_en) begin
            stream_done = 1'b1;
            add_event(sccsp_pkg::KIND_END, 3'd0, 2'd0, 8'd0, 32'd0, 16'd0, 1'b1);
          end else begin
            if (loop_cnt != 16'hFFFF) loop_cnt++;
            add_event(sccsp_pkg::KIND_LOOP, 3'd0, 2'd0, 8'd0, 32'd0, loop_cnt, 1'b1);
          end
        end else begin
          hold_dev = b[7:1];
          hold_port = b[0];
          phase = sccsp_pkg::PH_REGISTER;
        end
      end
      sccsp_pkg::PH_REGISTER: begin
        hold_reg = b;
        phase = sccsp_pkg::PH_DATA;
      end
      sccsp_pkg::PH_DATA: begin
        limit = (cfg_dev_count > MaxDevices) ? 4'(MaxDevices) : cfg_dev_count;
        phase = sccsp_pkg::PH_OPCODE;
        if (hold_dev < limit) begin
          psg = (hold_dev < 7'd8) && cfg_psg_mask[hold_dev[2:0]];
          if (psg) begin
            add_event(sccsp_pkg::KIND_WRITE, hold_dev[2:0],
                      (hold_reg == 8'd1) ? 2'd1 : 2'd0, b, 32'd0, 16'd0, 1'b1);
          end else begin
            add_event(sccsp_pkg::KIND_WRITE, hold_dev[2:0], {hold_port, 1'b0}, hold_reg,
                      32'd0, 16'd0, 1'b0);
            add_event(sccsp_pkg::KIND_WRITE, hold_dev[2:0], {hold_port, 1'b1}, b,
                      32'd0, 16'd0, 1'b1);
          end
        end
      end
      default: begin
        // only the first five groups count, later ones are just consumed
        if (delay_bytes < sccsp_pkg::DelayMaxBytes) begin
          delay_sum = sat32({8'd0, delay_sum} + (40'(b[6:0]) << (7 * delay_bytes)));
          delay_bytes++;
        end
        if (!b[7]) begin
          phase = sccsp_pkg::PH_OPCODE;
          add_event(sccsp_pkg::KIND_WAIT, 3'd0, 2'd0, 8'd0,
                    sat32({8'd0, delay_sum} + 40'd2), 16'd0, 1'b1);
          delay_sum = '0;
          delay_bytes = '0;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Keeps a stray loop opcode from ending the stream while looping is off
  function automatic logic [7:0] safe_byte(input logic [7:0] b);
    return (b == sccsp_pkg::OpLoop && !cfg_loop_en) ? b - 8'd1 : b;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic eos);
    stream_req_t r;
    r.value  = b;
    r.at_end = eos;
    pending_bytes.push_back(r);
    queued_bytes++;
  endfunction

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      sccsp_pkg::CFG_LOOP_EN:   cfg_loop_en = data[0];
      sccsp_pkg::CFG_DEV_COUNT: cfg_dev_count = data[3:0];
      sccsp_pkg::CFG_PSG_MASK:  cfg_psg_mask = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || due_events.size() != 0);
    // dropped writes and open delays leave nothing to wait for
    repeat (4) @(posedge clk_i);
  endtask

  task automatic fill_random(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    start = queued_bytes;
    while (queued_bytes - start < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) b = 8'($urandom_range(8'hFC));
        else b = 8'(($urandom_range(9) << 1) | $urandom_range(1));
        push_byte(safe_byte(b), 1'b0);
        b = ($urandom_range(3) == 0) ? 8'd1 : 8'($urandom_range(255));
        push_byte(safe_byte(b), 1'b0);
        push_byte(safe_byte(8'($urandom_range(255))), 1'b0);
      end else if (pick < 55) begin
        push_byte(sccsp_pkg::OpWaitOne, 1'b0);
      end else if (pick < 72) begin
        push_byte(sccsp_pkg::OpDelay, 1'b0);
        len = ($urandom_range(7) == 0) ? $urandom_range(8, 6) : $urandom_range(3, 1);
        for (int unsigned i = 0; i < len; i++) begin
          b = ($urandom_range(3) == 0) ? 8'h7F : 8'($urandom_range(127));
          if (i + 1 < len) b = b | 8'h80;
          push_byte(safe_byte(b), 1'b0);
        end
      end else if (pick < 82) begin
        push_byte(cfg_loop_en ? sccsp_pkg::OpLoop : sccsp_pkg::OpWaitOne, 1'b0);
      end else begin
        len = $urandom_range(3, 1);
        for (int unsigned i = 0; i < len; i++)
          push_byte(safe_byte(8'($urandom_range(255))), 1'b0);
      end
    end
  endtask

  // Driver: next request goes out once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) parse_byte(stream_byte_i, stream_end_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_req = pending_bytes.pop_front();
          in_valid_i    <= 1'b1;
          stream_byte_i <= next_req.value;
          stream_end_i  <= next_req.at_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
      if (out_valid_o && out_ready_i) begin
        if (due_events.size() == 0) begin
          $error("result with nothing due: kind %0d device %0d value %0h", kind_o,
                 device_o, value_o);
          fail_count++;
        end else begin
          want_ev = due_events.pop_front();
          check_field("kind", 32'(want_ev.kind), 32'(kind_o));
          check_field("device", 32'(want_ev.device), 32'(device_o));
          check_field("offset", 32'(want_ev.offset), 32'(offset_o));
          check_field("value", 32'(want_ev.value), 32'(value_o));
          check_field("wait_ticks", want_ev.wait_ticks, wait_ticks_o);
          check_field("loop_number", 32'(want_ev.loop_number), 32'(loop_number_o));
          check_field("last", 32'(want_ev.last), 32'(last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned end_mode;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: one two-port device, no looping
    @(negedge clk_i);
    push_byte(8'h01, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h5B, 1'b0);
    push_byte(8'h02, 1'b0); push_byte(8'h10, 1'b0); push_byte(8'h20, 1'b0);
    wait_idle();

    write_cfg(sccsp_pkg::CFG_LOOP_EN, 8'h01);
    write_cfg(sccsp_pkg::CFG_DEV_COUNT, 8'h08);
    write_cfg(sccsp_pkg::CFG_PSG_MASK, 8'hA5);
    write_cfg(CfgUnused, 8'h00);
    @(negedge clk_i);
    push_byte(sccsp_pkg::OpWaitOne, 1'b0);
    // saturating delay with a sixth group that is ignored
    push_byte(sccsp_pkg::OpDelay, 1'b0);
    repeat (5) push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(sccsp_pkg::OpLoop, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hAA, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h0F, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h10, 1'b0); push_byte(8'h07, 1'b0); push_byte(8'h07, 1'b0);
    wait_idle();

    for (int unsigned blk = 0; blk < 9; blk++) begin
      write_cfg(sccsp_pkg::CFG_LOOP_EN, {7'($urandom), loop_plan[blk]});
      write_cfg(sccsp_pkg::CFG_DEV_COUNT, {4'($urandom), 4'(count_plan[blk])});
      write_cfg(sccsp_pkg::CFG_PSG_MASK, mask_plan[blk]);
      @(negedge clk_i);
      if (blk < 3) begin
        send_idle = 37;
        recv_idle = 54;
      end else if (blk < 6) begin
        send_idle = 54;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      fill_random(50);
      wait_idle();
    end

    // Finish the stream once, then show that later requests are ignored
    end_mode = $urandom_range(2);
    if (end_mode == 0 && phase == sccsp_pkg::PH_OPCODE) begin
      write_cfg(sccsp_pkg::CFG_LOOP_EN, 8'h00);
      @(negedge clk_i);
      push_byte(sccsp_pkg::OpLoop, 1'b0);
    end else begin
      @(negedge clk_i);
      if (end_mode == 2) begin
        push_byte(sccsp_pkg::OpDelay, 1'b0);
        push_byte(8'h81, 1'b0);
      end else begin
        push_byte(8'($urandom_range(19)), 1'b0);
      end
      push_byte(8'($urandom_range(255)), 1'b1);
    end
    push_byte(8'($urandom_range(255)), 1'b1);
    push_byte(sccsp_pkg::OpWaitOne, 1'b0);
    repeat (4) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sccsp_pkg.sv
src/sccsp_parser.sv
src/sound_chip_command_stream_parser_unit.sv
test/tb.sv
